/* rtl/psg_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the pulse and sawtooth sound generator.
// No dependencies; every other file in rtl/ imports this package.
package psg_pkg;

    // Bus page selects, taken from address bits 15..12.
    localparam logic [3:0] PAGE_PULSE_ONE = 4'h9;
    localparam logic [3:0] PAGE_PULSE_TWO = 4'hA;
    localparam logic [3:0] PAGE_SAW       = 4'hB;

    // Register select within a page, from the (possibly swapped) low address bits.
    localparam logic [1:0] REG_CTRL      = 2'd0;
    localparam logic [1:0] REG_PERIOD_LO = 2'd1;
    localparam logic [1:0] REG_PERIOD_HI = 2'd2;

    // Item opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    // Field widths.
    localparam int PERIOD_W    = 12;
    localparam int COUNTDOWN_W = PERIOD_W + 1;
    localparam int PHASE_W     = 4;
    localparam int VOLUME_W    = 4;
    localparam int DUTY_W      = 3;
    localparam int SAW_RATE_W  = 6;
    localparam int SAW_W       = 8;

    // The saw sequencer restarts when its step count reaches this value.
    localparam logic [PHASE_W-1:0] SAW_PHASE_WRAP = 4'd14;

    // Register write strobes for one channel.
    typedef struct packed {
        logic ctrl_we;
        logic period_lo_we;
        logic period_hi_we;
    } psg_wr_t;

endpackage

/* rtl/pulse_and_sawtooth_sound_generator.sv */
`timescale 1ns / 1ps
// Top level of the pulse and sawtooth sound generator.
// Depends on psg_pkg, psg_decode, psg_pulse and psg_saw.
//
// Each item is either a register write or one audio tick, and each item
// gives exactly one result with the three channel levels after it. The block
// takes one item per clock cycle while in_stall is low; an item is held in
// an input register, is applied to the channel state by combinational logic,
// and its result lands in the output register. The input register keeps
// taking an item while a finished result waits, and stalls upstream only
// when both it and the output register are full. The address line swap
// register is meant to be written while no item is in flight.
module pulse_and_sawtooth_sound_generator
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  pulse_one_level,
    output logic [3:0]  pulse_two_level,
    output logic [7:0]  saw_level,
    output logic        any_channel_clocked
);

    logic        swap_reg;
    logic        s1_valid_reg;
    logic        s1_op_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_data_reg;
    logic        out_valid_reg;
    logic [3:0]  pulse_one_reg;
    logic [3:0]  pulse_two_reg;
    logic [7:0]  saw_reg;
    logic        clocked_reg;

    logic        advance;
    logic        in_take;
    logic        tick;
    logic        write_en;
    psg_wr_t     pulse_one_wr;
    psg_wr_t     pulse_two_wr;
    psg_wr_t     saw_wr;
    logic [3:0]  pulse_one_next;
    logic [3:0]  pulse_two_next;
    logic [7:0]  saw_next;
    logic        pulse_one_fired;
    logic        pulse_two_fired;
    logic        saw_fired;

    // Handshake: the held item is applied when the output register can take its result.
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;
    assign tick     = advance && (s1_op_reg == OP_TICK);
    assign write_en = advance && (s1_op_reg == OP_WRITE);

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            swap_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            swap_reg <= cfg_write_data;
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take || advance)
        begin
            s1_valid_reg <= in_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg      <= op;
            s1_address_reg <= address;
            s1_data_reg    <= data;
        end
    end

    // Register write decode.
    psg_decode u_decode (
        .write_en     (write_en),
        .swap         (swap_reg),
        .address      (s1_address_reg),
        .pulse_one_wr (pulse_one_wr),
        .pulse_two_wr (pulse_two_wr),
        .saw_wr       (saw_wr)
    );

    // Channels.
    psg_pulse u_pulse_one (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (pulse_one_wr),
        .data       (s1_data_reg),
        .tick       (tick),
        .level_next (pulse_one_next),
        .fired      (pulse_one_fired)
    );

    psg_pulse u_pulse_two (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (pulse_two_wr),
        .data       (s1_data_reg),
        .tick       (tick),
        .level_next (pulse_two_next),
        .fired      (pulse_two_fired)
    );

    psg_saw u_saw (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr         (saw_wr),
        .data       (s1_data_reg),
        .tick       (tick),
        .level_next (saw_next),
        .fired      (saw_fired)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pulse_one_reg <= pulse_one_next;
            pulse_two_reg <= pulse_two_next;
            saw_reg       <= saw_next;
            clocked_reg   <= pulse_one_fired || pulse_two_fired || saw_fired;
        end
    end

    assign out_valid           = out_valid_reg;
    assign pulse_one_level     = pulse_one_reg;
    assign pulse_two_level     = pulse_two_reg;
    assign saw_level           = saw_reg;
    assign any_channel_clocked = clocked_reg;

endmodule

/* rtl/psg_decode.sv */
`timescale 1ns / 1ps
// Bus address decoder: turns one write item into per-channel register strobes.
// Depends on psg_pkg.
module psg_decode
    import psg_pkg::*;
(
    input  logic        write_en,
    input  logic        swap,
    input  logic [15:0] address,
    output psg_wr_t     pulse_one_wr,
    output psg_wr_t     pulse_two_wr,
    output psg_wr_t     saw_wr
);

    logic [1:0] low;
    logic [3:0] page;
    psg_wr_t    strobe;

    // Optional swap of the two low address lines, then register select.
    always_comb
    begin
        low  = swap ? {address[0], address[1]} : address[1:0];
        page = address[15:12];
        strobe.ctrl_we      = write_en && (low == REG_CTRL);
        strobe.period_lo_we = write_en && (low == REG_PERIOD_LO);
        strobe.period_hi_we = write_en && (low == REG_PERIOD_HI);
    end

    // Page select routes the strobes to one channel.
    always_comb
    begin
        pulse_one_wr = '0;
        pulse_two_wr = '0;
        saw_wr       = '0;
        case (page)
            PAGE_PULSE_ONE: pulse_one_wr = strobe;
            PAGE_PULSE_TWO: pulse_two_wr = strobe;
            PAGE_SAW:       saw_wr       = strobe;
            default:        ;
        endcase
    end

endmodule

/* rtl/psg_pulse.sv */
`timescale 1ns / 1ps
// One pulse channel: registers, period counter and 16-step duty sequencer.
// Depends on psg_pkg.
module psg_pulse
    import psg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  psg_wr_t             wr,
    input  logic [7:0]          data,
    input  logic                tick,
    output logic [VOLUME_W-1:0] level_next,
    output logic                fired
);

    logic [VOLUME_W-1:0]    volume_reg;
    logic [DUTY_W-1:0]      duty_reg;
    logic                   constant_reg;
    logic                   enable_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [COUNTDOWN_W-1:0] countdown_reg;
    logic [COUNTDOWN_W-1:0] countdown_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [VOLUME_W-1:0]    level_reg;
    logic [COUNTDOWN_W-1:0] count_dec;

    // Tick: count down, on expiry reload and advance the duty sequencer.
    always_comb
    begin
        count_dec      = countdown_reg - 1'b1;
        countdown_next = countdown_reg;
        phase_next     = phase_reg;
        level_next     = level_reg;
        fired          = 1'b0;
        if (tick)
        begin
            countdown_next = count_dec;
            if (count_dec == '0)
            begin
                fired          = 1'b1;
                phase_next     = phase_reg + 1'b1;
                countdown_next = {1'b0, period_reg} + 1'b1;
                if (enable_reg)
                begin
                    level_next = (constant_reg || (phase_next <= {1'b0, duty_reg}))
                                 ? volume_reg : '0;
                end
            end
            if (!enable_reg)
            begin
                level_next = '0;
            end
        end
    end

    // Channel registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            volume_reg    <= '0;
            duty_reg      <= DUTY_W'(1);
            constant_reg  <= 1'b0;
            enable_reg    <= 1'b0;
            period_reg    <= '0;
            countdown_reg <= COUNTDOWN_W'(1);
            phase_reg     <= '0;
            level_reg     <= '0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            phase_reg     <= phase_next;
            level_reg     <= level_next;
            if (wr.ctrl_we)
            begin
                volume_reg   <= data[3:0];
                duty_reg     <= data[6:4];
                constant_reg <= data[7];
            end
            if (wr.period_lo_we)
            begin
                period_reg[7:0] <= data;
            end
            if (wr.period_hi_we)
            begin
                period_reg[11:8] <= data[3:0];
                enable_reg       <= data[7];
            end
        end
    end

endmodule

/* rtl/psg_saw.sv */
`timescale 1ns / 1ps
// Sawtooth channel: rate accumulator stepped by its own period counter.
// Depends on psg_pkg.
module psg_saw
    import psg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  psg_wr_t          wr,
    input  logic [7:0]       data,
    input  logic             tick,
    output logic [SAW_W-1:0] level_next,
    output logic             fired
);

    logic [SAW_RATE_W-1:0]  rate_reg;
    logic                   enable_reg;
    logic [PERIOD_W-1:0]    period_reg;
    logic [COUNTDOWN_W-1:0] countdown_reg;
    logic [COUNTDOWN_W-1:0] countdown_next;
    logic [PHASE_W-1:0]     phase_reg;
    logic [PHASE_W-1:0]     phase_next;
    logic [PHASE_W-1:0]     phase_inc;
    logic [SAW_W-1:0]       sum_reg;
    logic [SAW_W-1:0]       sum_next;
    logic [SAW_W-1:0]       sum_add;
    logic [SAW_W-1:0]       level_reg;
    logic [COUNTDOWN_W-1:0] count_dec;

    // Tick: on expiry add the rate on nonzero even steps, restart after the last step.
    always_comb
    begin
        count_dec      = countdown_reg - 1'b1;
        phase_inc      = phase_reg + 1'b1;
        sum_add        = ((phase_reg != '0) && !phase_reg[0])
                         ? sum_reg + {2'b00, rate_reg} : sum_reg;
        countdown_next = countdown_reg;
        phase_next     = phase_reg;
        sum_next       = sum_reg;
        level_next     = level_reg;
        fired          = 1'b0;
        if (tick)
        begin
            countdown_next = count_dec;
            if (count_dec == '0)
            begin
                fired          = 1'b1;
                countdown_next = {1'b0, period_reg} + 1'b1;
                if (phase_inc >= SAW_PHASE_WRAP)
                begin
                    phase_next = '0;
                    sum_next   = '0;
                end
                else
                begin
                    phase_next = phase_inc;
                    sum_next   = sum_add;
                end
                if (enable_reg)
                begin
                    level_next = sum_next;
                end
            end
        end
    end

    // Channel registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= '0;
            enable_reg    <= 1'b0;
            period_reg    <= '0;
            countdown_reg <= COUNTDOWN_W'(1);
            phase_reg     <= '0;
            sum_reg       <= '0;
            level_reg     <= '0;
        end
        else
        begin
            countdown_reg <= countdown_next;
            phase_reg     <= phase_next;
            sum_reg       <= sum_next;
            level_reg     <= level_next;
            if (wr.ctrl_we)
            begin
                rate_reg <= data[5:0];
            end
            if (wr.period_lo_we)
            begin
                period_reg[7:0] <= data;
            end
            if (wr.period_hi_we)
            begin
                period_reg[11:8] <= data[3:0];
                enable_reg       <= data[7];
            end
        end
    end

endmodule

/* tb/psg_level_checker.sv */
`timescale 1ns / 1ps
// Checker for the pulse and sawtooth sound generator: predicts the channel levels
// of every accepted item and compares them with the results. Depends on psg_pkg.
module psg_level_checker
    import psg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        op,
    input  logic [15:0] address,
    input  logic [7:0]  data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  pulse_one_level,
    input  logic [3:0]  pulse_two_level,
    input  logic [7:0]  saw_level,
    input  logic        any_channel_clocked,
    output int          failures,
    output int          pending
);

    // Register and sequencer state of one pulse channel.
    typedef struct packed {
        logic [VOLUME_W-1:0]    volume;
        logic [DUTY_W-1:0]      duty;
        logic                   constant_mode;
        logic                   enable;
        logic [PERIOD_W-1:0]    period;
        logic [COUNTDOWN_W-1:0] countdown;
        logic [PHASE_W-1:0]     phase;
        logic [VOLUME_W-1:0]    level;
    } pulse_chan_t;

    // The levels reported for one item.
    typedef struct packed {
        logic [3:0] pulse_one;
        logic [3:0] pulse_two;
        logic [7:0] saw;
        logic       clocked;
    } levels_t;

    pulse_chan_t             pulse_chan [2];
    logic [SAW_RATE_W-1:0]   saw_rate;
    logic                    saw_enable;
    logic [PERIOD_W-1:0]     saw_period;
    logic [COUNTDOWN_W-1:0]  saw_countdown;
    logic [PHASE_W-1:0]      saw_phase;
    logic [SAW_W-1:0]        saw_sum;
    logic [SAW_W-1:0]        saw_out;
    logic                    swap_lines;
    levels_t                 expected_levels [$];
    int                      mismatch_count;
    int                      result_count;

    function automatic void clear_channels();
        for (int i = 0; i < 2; i++)
        begin
            pulse_chan[i] = '0;
            pulse_chan[i].duty = 3'd1;
            pulse_chan[i].countdown = 13'd1;
        end
        saw_rate = '0;
        saw_enable = 1'b0;
        saw_period = '0;
        saw_countdown = 13'd1;
        saw_phase = '0;
        saw_sum = '0;
        saw_out = '0;
        swap_lines = 1'b0;
    endfunction

    // One tick of a pulse channel; returns 1 when its period counter expires.
    function automatic logic tick_pulse(int idx);
        logic fired;
        fired = 1'b0;
        pulse_chan[idx].countdown = pulse_chan[idx].countdown - 13'd1;
        if (pulse_chan[idx].countdown == '0)
        begin
            pulse_chan[idx].phase = pulse_chan[idx].phase + 4'd1;
            pulse_chan[idx].countdown = {1'b0, pulse_chan[idx].period} + 13'd1;
            if (pulse_chan[idx].enable)
            begin
                if (pulse_chan[idx].constant_mode
                    || pulse_chan[idx].phase <= {1'b0, pulse_chan[idx].duty})
                    pulse_chan[idx].level = pulse_chan[idx].volume;
                else
                    pulse_chan[idx].level = '0;
            end
            fired = 1'b1;
        end
        // A disabled channel is silent, but its counters keep running.
        if (!pulse_chan[idx].enable)
            pulse_chan[idx].level = '0;
        return fired;
    endfunction

    // One tick of the saw channel: the rate is added on nonzero even steps.
    function automatic logic tick_saw();
        saw_countdown = saw_countdown - 13'd1;
        if (saw_countdown != '0)
            return 1'b0;
        saw_countdown = {1'b0, saw_period} + 13'd1;
        if (saw_phase != '0 && !saw_phase[0])
            saw_sum = saw_sum + {2'b00, saw_rate};
        saw_phase = saw_phase + 4'd1;
        if (saw_phase >= SAW_PHASE_WRAP)
        begin
            saw_phase = '0;
            saw_sum = '0;
        end
        if (saw_enable)
            saw_out = saw_sum;
        return 1'b1;
    endfunction

    // Register write as decoded by the block, with the optional line swap.
    function automatic void apply_bus_write(logic [15:0] addr, logic [7:0] wdata);
        logic [1:0] sel;
        int         idx;
        sel = swap_lines ? {addr[0], addr[1]} : addr[1:0];
        if (addr[15:12] == PAGE_SAW)
        begin
            case (sel)
                REG_CTRL:      saw_rate = wdata[5:0];
                REG_PERIOD_LO: saw_period[7:0] = wdata;
                REG_PERIOD_HI:
                begin
                    saw_period[11:8] = wdata[3:0];
                    saw_enable = wdata[7];
                end
                default: ;
            endcase
            return;
        end
        if (addr[15:12] == PAGE_PULSE_ONE)
            idx = 0;
        else if (addr[15:12] == PAGE_PULSE_TWO)
            idx = 1;
        else
            return;
        case (sel)
            REG_CTRL:
            begin
                pulse_chan[idx].volume = wdata[3:0];
                pulse_chan[idx].duty = wdata[6:4];
                pulse_chan[idx].constant_mode = wdata[7];
            end
            REG_PERIOD_LO: pulse_chan[idx].period[7:0] = wdata;
            REG_PERIOD_HI:
            begin
                pulse_chan[idx].period[11:8] = wdata[3:0];
                pulse_chan[idx].enable = wdata[7];
            end
            default: ;
        endcase
    endfunction

    function automatic levels_t predict_levels(logic kind, logic [15:0] addr,
                                               logic [7:0] wdata);
        levels_t lv;
        logic    a;
        logic    b;
        logic    c;
        if (kind == OP_TICK)
        begin
            a = tick_pulse(0);
            b = tick_pulse(1);
            c = tick_saw();
            lv.clocked = a | b | c;
        end
        else
        begin
            apply_bus_write(addr, wdata);
            lv.clocked = 1'b0;
        end
        lv.pulse_one = pulse_chan[0].level;
        lv.pulse_two = pulse_chan[1].level;
        lv.saw = saw_out;
        return lv;
    endfunction

    // Predict on every accepted item and compare every accepted result.
    always @(posedge clk or negedge rst_n)
    begin
        levels_t want;
        levels_t got;
        if (!rst_n)
        begin
            clear_channels();
            expected_levels.delete();
            mismatch_count = 0;
            result_count = 0;
            failures <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_write_en)
                swap_lines = cfg_write_data;
            if (in_valid && !in_stall)
                expected_levels.push_back(predict_levels(op, address, data));
            if (out_valid && !out_stall)
            begin
                got = {pulse_one_level, pulse_two_level, saw_level, any_channel_clocked};
                if (expected_levels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result %0d arrived with none expected: p1=%0d p2=%0d saw=%0d clk=%0b",
                                 $realtime, result_count, got.pulse_one, got.pulse_two,
                                 got.saw, got.clocked);
                end
                else
                begin
                    want = expected_levels.pop_front();
                    if (got.pulse_one !== want.pulse_one || got.pulse_two !== want.pulse_two
                        || got.saw !== want.saw || got.clocked !== want.clocked)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: result %0d expected p1=%0d p2=%0d saw=%0d clk=%0b, got p1=%0d p2=%0d saw=%0d clk=%0b",
                                     $realtime, result_count, want.pulse_one, want.pulse_two,
                                     want.saw, want.clocked, got.pulse_one, got.pulse_two,
                                     got.saw, got.clocked);
                    end
                end
                result_count++;
            end
            failures <= mismatch_count;
            pending <= expected_levels.size();
        end
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the sound generator testbench: clock, reset, item and stall stimulus, verdict.
// Depends on psg_pkg, the generator RTL and psg_level_checker.
module testbench;
    import psg_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        op = OP_WRITE;
    logic [15:0] address = '0;
    logic [7:0]  data = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [3:0]  pulse_one_level;
    logic [3:0]  pulse_two_level;
    logic [7:0]  saw_level;
    logic        any_channel_clocked;
    int          failures;
    int          pending;
    logic        cur_swap = 1'b0;
    logic        calm = 1'b0;

    pulse_and_sawtooth_sound_generator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .address(address), .data(data),
        .out_valid(out_valid), .out_stall(out_stall),
        .pulse_one_level(pulse_one_level), .pulse_two_level(pulse_two_level),
        .saw_level(saw_level), .any_channel_clocked(any_channel_clocked)
    );

    psg_level_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .op(op), .address(address), .data(data),
        .out_valid(out_valid), .out_stall(out_stall),
        .pulse_one_level(pulse_one_level), .pulse_two_level(pulse_two_level),
        .saw_level(saw_level), .any_channel_clocked(any_channel_clocked),
        .failures(failures), .pending(pending)
    );

    always #2 clk = ~clk;

    // Idle cycles before an item: mostly none or a few, now and then a long pause.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // Offer one item and hold it until the block accepts it.
    task automatic push_item(input logic kind, input logic [15:0] addr, input logic [7:0] wdata);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        address <= addr;
        data <= wdata;
        do @(posedge clk); while (!(in_valid && !in_stall));
    endtask

    // Wait until every result is in, plus a margin.
    task automatic wait_idle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_line_swap(input logic value);
        wait_idle();
        cfg_write_en <= 1'b1;
        cfg_write_data <= value;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        cur_swap = value;
    endtask

    // A register write, mostly to a real register with short periods so that the
    // sequencers run through all their steps; some writes go anywhere.
    function automatic void random_write(output logic [15:0] addr, output logic [7:0] wdata);
        logic [3:0] page;
        logic [1:0] low;
        logic [1:0] sel;
        logic       en;
        int         pick;
        addr = 16'($urandom);
        wdata = 8'($urandom);
        if ($urandom_range(99, 0) < 12)
            return;
        pick = $urandom_range(2, 0);
        page = (pick == 0) ? PAGE_PULSE_ONE : (pick == 1) ? PAGE_PULSE_TWO : PAGE_SAW;
        low = 2'($urandom_range(3, 0));
        addr = {page, addr[11:2], low};
        sel = cur_swap ? {low[0], low[1]} : low;
        if (sel == REG_PERIOD_LO && $urandom_range(3, 0) != 0)
            wdata = 8'($urandom_range(7, 0));
        else if (sel == REG_PERIOD_HI && $urandom_range(4, 0) != 0)
        begin
            en = ($urandom_range(6, 0) != 0);
            wdata = {en, 3'($urandom), 4'h0};
        end
    endfunction

    task automatic run_random(input int count);
        logic [15:0] addr;
        logic [7:0]  wdata;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(149, 0) == 0)
                calm = !calm;
            if ($urandom_range(99, 0) < 70)
                push_item(OP_TICK, 16'($urandom), 8'($urandom));
            else
            begin
                random_write(addr, wdata);
                push_item(OP_WRITE, addr, wdata);
            end
        end
    endtask

    // Result side stall: runs of ready cycles, short stalls and an occasional long one.
    initial
    begin
        int run;
        int hold;
        forever
        begin
            run = ($urandom_range(9, 0) == 0) ? $urandom_range(200, 20) : $urandom_range(6, 1);
            out_stall <= 1'b0;
            repeat (run) @(posedge clk);
            hold = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 10) : $urandom_range(4, 1);
            out_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
    end

    initial
    begin
        #(5_000_000);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_line_swap(1'b0);

        // Directed part: every register, extreme fields, ignored addresses, ticks.
        push_item(OP_TICK, 16'h0000, 8'h00);
        push_item(OP_WRITE, 16'h9000, 8'hFF);
        push_item(OP_WRITE, 16'h9001, 8'h00);
        push_item(OP_WRITE, 16'h9002, 8'h80);
        push_item(OP_WRITE, 16'hA000, 8'h3A);
        push_item(OP_WRITE, 16'hA001, 8'h01);
        push_item(OP_WRITE, 16'hA002, 8'h80);
        push_item(OP_WRITE, 16'hB000, 8'hFF);
        push_item(OP_WRITE, 16'hB001, 8'h00);
        push_item(OP_WRITE, 16'hB002, 8'h80);
        push_item(OP_WRITE, 16'h9003, 8'h00);
        push_item(OP_WRITE, 16'hA003, 8'hFF);
        push_item(OP_WRITE, 16'hB003, 8'hFF);
        push_item(OP_WRITE, 16'h0000, 8'h00);
        push_item(OP_WRITE, 16'hFFFF, 8'hFF);
        push_item(OP_WRITE, 16'h9FFD, 8'h01);
        repeat (6) push_item(OP_TICK, 16'h0000, 8'h00);
        // Disabling a channel silences it on the next tick.
        push_item(OP_WRITE, 16'h9002, 8'h0F);
        repeat (2) push_item(OP_TICK, 16'hFFFF, 8'hFF);

        // Random part under both address line settings.
        set_line_swap(1'b1);
        run_random(480);
        set_line_swap(1'b0);
        run_random(480);
        set_line_swap(1'b1);
        run_random(490);
        wait_idle();

        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
